>>> hdl/dscu_pkg.sv
// shared types, constants and tables for the degree sine/cosine unit
package dscu_pkg;

    localparam int ANGLE_W         = 32;
    localparam int OUT_W           = 16;
    localparam int CORDIC_STAGES   = 16;
    localparam int ANGLE_FRAC_BITS = 16;
    localparam int ATAN_LEN        = 30;
    localparam int NUM_CELLS       = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
    localparam int STAGE_W         = $clog2(ATAN_LEN);

    // datapath width of the rotation cells, q2.30 with headroom
    localparam int CW = 34;

    // integer part of the angle magnitude and the divide-by-90 reciprocal
    localparam int N_W         = ANGLE_W - ANGLE_FRAC_BITS;
    localparam int RECIP_SHIFT = N_W + 7;
    localparam int RECIP_W     = N_W + 1;
    localparam int PROD1_W     = N_W + RECIP_W;
    localparam int Q_W         = N_W - 6;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((64'd1 << RECIP_SHIFT) + 64'd89) / 64'd90);

    // remainder widths: below 90 degrees, and below 45 degrees after rounding
    localparam int REM_W  = ANGLE_FRAC_BITS + 7;
    localparam int RMAG_W = ANGLE_FRAC_BITS + 6;
    localparam logic [REM_W-1:0] QUARTER_DEG = REM_W'(90) << ANGLE_FRAC_BITS;
    localparam logic [REM_W-1:0] EIGHTH_DEG  = REM_W'(45) << ANGLE_FRAC_BITS;

    // degrees to q2.30 radians
    localparam int DEG2RAD_W = 27;
    localparam logic [DEG2RAD_W-1:0] DEG2RAD = DEG2RAD_W'(74961321);
    localparam int PROD2_W = RMAG_W + DEG2RAD_W + 1;
    localparam int ZMAG_W  = PROD2_W - (ANGLE_FRAC_BITS + 2);

    localparam logic signed [CW-1:0] CORDIC_GAIN = CW'(652032874);

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW-1:0] z;
        logic [1:0]           quad;
        logic                 neg;
    } t_rot;

    // atan(2^-i) in q30
    function automatic logic [29:0] atan_q30(input logic [STAGE_W-1:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314857;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043837;
            5'd3:  v = 30'd133525159;
            5'd4:  v = 30'd67021687;
            5'd5:  v = 30'd33543516;
            5'd6:  v = 30'd16775851;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194283;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048576;
            5'd11: v = 30'd524288;
            5'd12: v = 30'd262144;
            5'd13: v = 30'd131072;
            5'd14: v = 30'd65536;
            5'd15: v = 30'd32768;
            5'd16: v = 30'd16384;
            5'd17: v = 30'd8192;
            5'd18: v = 30'd4096;
            5'd19: v = 30'd2048;
            5'd20: v = 30'd1024;
            5'd21: v = 30'd512;
            5'd22: v = 30'd256;
            5'd23: v = 30'd128;
            5'd24: v = 30'd64;
            5'd25: v = 30'd32;
            5'd26: v = 30'd16;
            5'd27: v = 30'd8;
            5'd28: v = 30'd4;
            5'd29: v = 30'd2;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/dscu_reduce.sv
// angle reduction modulo 90 degrees and conversion to q2.30 radians, three stages
module dscu_reduce import dscu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [ANGLE_W-1:0] i_angle,
    output logic               o_ready,
    input  logic               i_ready,
    output logic               o_valid,
    output t_rot               o_data
);

    logic               r_v1, r_v2, r_v3;
    logic               rdy1, rdy2, rdy3;

    logic [ANGLE_W-1:0] r_a;
    logic               r_neg1;
    logic [PROD1_W-1:0] r_prod1;

    logic [RMAG_W-1:0]  r_rmag;
    logic               r_rneg;
    logic [1:0]         r_quad2;
    logic               r_neg2;

    t_rot               r_out;

    logic [ANGLE_W-1:0] n_a;
    logic [PROD1_W-1:0] n_prod1;
    logic [Q_W-1:0]     q;
    logic [N_W-1:0]     q90;
    logic [ANGLE_W-1:0] diff;
    logic [REM_W-1:0]   rem;
    logic               round_up;
    logic [REM_W-1:0]   rmag_full;
    logic [RMAG_W-1:0]  n_rmag;
    logic [1:0]         n_quad;
    logic [PROD2_W-1:0] prod2;
    logic [ZMAG_W-1:0]  zmag;
    logic signed [CW-1:0] zext;
    t_rot               n_out;

    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;
    assign o_valid = r_v3;
    assign o_data  = r_out;

    // stage 1: magnitude and quotient estimate by reciprocal
    always_comb begin
        n_a     = i_angle[ANGLE_W-1] ? (~i_angle + ANGLE_W'(1)) : i_angle;
        n_prod1 = PROD1_W'(n_a[ANGLE_W-1:ANGLE_FRAC_BITS]) * PROD1_W'(RECIP);
    end

    // stage 2: remainder and round to nearest, ties to even
    always_comb begin
        q         = r_prod1[PROD1_W-1 -: Q_W];
        q90       = N_W'(q) * N_W'(90);
        diff      = r_a - {q90, {ANGLE_FRAC_BITS{1'b0}}};
        rem       = diff[REM_W-1:0];
        round_up  = (rem > EIGHTH_DEG) || ((rem == EIGHTH_DEG) && q[0]);
        rmag_full = round_up ? (QUARTER_DEG - rem) : rem;
        n_rmag    = rmag_full[RMAG_W-1:0];
        n_quad    = q[1:0] + {1'b0, round_up};
    end

    // stage 3: degrees to radians
    always_comb begin
        prod2 = PROD2_W'(r_rmag) * PROD2_W'(DEG2RAD)
              + (PROD2_W'(1) << (ANGLE_FRAC_BITS + 1));
        zmag  = prod2[PROD2_W-1:ANGLE_FRAC_BITS+2];
        zext  = CW'(zmag);
        n_out.x    = CORDIC_GAIN;
        n_out.y    = '0;
        n_out.z    = r_rneg ? -zext : zext;
        n_out.quad = r_quad2;
        n_out.neg  = r_neg2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r_a     <= n_a;
            r_neg1  <= i_angle[ANGLE_W-1];
            r_prod1 <= n_prod1;
        end
        if (rdy2 && r_v1) begin
            r_rmag  <= n_rmag;
            r_rneg  <= round_up;
            r_quad2 <= n_quad;
            r_neg2  <= r_neg1;
        end
        if (rdy3 && r_v2) begin
            r_out <= n_out;
        end
    end

endmodule

>>> hdl/dscu_cell.sv
// one cordic rotation cell: holds one item and hands it to the next cell
module dscu_cell import dscu_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic [STAGE_W-1:0] i_stage,
    input  logic               i_valid,
    input  t_rot               i_data,
    output logic               o_ready,
    input  logic               i_ready,
    output logic               o_valid,
    output t_rot               o_data
);

    logic                 r_valid;
    t_rot                 r_data;
    t_rot                 n_data;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;
    logic signed [CW-1:0] ang;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        dx     = i_data.y >>> i_stage;
        dy     = i_data.x >>> i_stage;
        ang    = CW'(atan_q30(i_stage));
        n_data = i_data;
        if (!i_data.z[CW-1]) begin
            n_data.x = i_data.x - dx;
            n_data.y = i_data.y + dy;
            n_data.z = i_data.z - ang;
        end else begin
            n_data.x = i_data.x + dx;
            n_data.y = i_data.y - dy;
            n_data.z = i_data.z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

>>> hdl/degree_sine_cosine_unit_core.sv
// sine and cosine of an angle in degrees: reduction, cordic cell chain, output rounding
//
// input channel: i_valid / o_stall with i_angle_deg, signed q16.16 degrees.
// output channel: o_valid / i_stall with o_sine_val and o_cosine_val, signed
// q1.15 saturated to +-32767.
// an item is taken on a rising edge where valid is high and stall is low.
// the path runs through three reduction stages (reciprocal multiply, remainder
// rounding, degree to radian multiply), a register in each cordic cell, and one
// output register for quadrant and rounding.
// throughput is one item per cycle while the receiver does not stall; every
// stage holds one item.
// when the receiver stalls, the item in the output register holds and each
// stage behind it keeps filling until it holds an item; o_stall rises only
// once the first reduction stage is full and cannot move.
// reset (synchronous, active low) empties every stage and drops the items in
// flight; it produces no item and the block is ready on the next cycle.
module degree_sine_cosine_unit_core import dscu_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic signed [ANGLE_W-1:0] i_angle_deg,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [OUT_W-1:0] o_sine_val,
    output logic signed [OUT_W-1:0] o_cosine_val
);

    logic   red_ready;
    logic   chain_valid [0:NUM_CELLS];
    logic   chain_ready [0:NUM_CELLS];
    t_rot   chain_data  [0:NUM_CELLS];

    logic   r_out_valid;
    logic   out_ready;
    t_rot   last;

    logic signed [CW-1:0] s_src;
    logic signed [CW-1:0] c_src;
    logic                 s_flip;
    logic                 c_flip;
    logic [OUT_W-1:0]     n_sine;
    logic [OUT_W-1:0]     n_cosine;
    logic [OUT_W-1:0]     r_sine;
    logic [OUT_W-1:0]     r_cosine;

    // symmetric rounding q30 to q15 with saturation, sign taken from v and flip
    function automatic logic [OUT_W-1:0] to_q15(input logic signed [CW-1:0] v,
                                                input logic flip);
        logic [CW-1:0]    mag;
        logic [CW-1:0]    sum;
        logic [CW-16:0]   m;
        logic [OUT_W-1:0] m16;
        logic             sgn;
        mag = v[CW-1] ? CW'(-v) : CW'(v);
        sum = mag + (CW'(1) << 14);
        m   = sum[CW-1:15];
        m16 = (m > (CW-15)'(32767)) ? OUT_W'(32767) : m[OUT_W-1:0];
        sgn = v[CW-1] ^ flip;
        return sgn ? (~m16 + OUT_W'(1)) : m16;
    endfunction

    dscu_reduce u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_angle (i_angle_deg),
        .o_ready (red_ready),
        .i_ready (chain_ready[0]),
        .o_valid (chain_valid[0]),
        .o_data  (chain_data[0])
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        dscu_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_stage (STAGE_W'(k)),
            .i_valid (chain_valid[k]),
            .i_data  (chain_data[k]),
            .o_ready (chain_ready[k]),
            .i_ready (chain_ready[k+1]),
            .o_valid (chain_valid[k+1]),
            .o_data  (chain_data[k+1])
        );
    end

    assign out_ready              = !r_out_valid || !i_stall;
    assign chain_ready[NUM_CELLS] = out_ready;
    assign o_stall                = !red_ready;
    assign last                   = chain_data[NUM_CELLS];

    // quadrant swap and negate, then odd symmetry for negative angles
    always_comb begin
        case (last.quad)
            QUAD_0: begin
                s_src = last.y; s_flip = 1'b0;
                c_src = last.x; c_flip = 1'b0;
            end
            QUAD_1: begin
                s_src = last.x; s_flip = 1'b0;
                c_src = last.y; c_flip = 1'b1;
            end
            QUAD_2: begin
                s_src = last.y; s_flip = 1'b1;
                c_src = last.x; c_flip = 1'b1;
            end
            QUAD_3: begin
                s_src = last.x; s_flip = 1'b1;
                c_src = last.y; c_flip = 1'b0;
            end
            default: begin
                s_src = last.y; s_flip = 1'b0;
                c_src = last.x; c_flip = 1'b0;
            end
        endcase
        n_sine   = to_q15(s_src, s_flip ^ last.neg);
        n_cosine = to_q15(c_src, c_flip);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_ready) begin
            r_out_valid <= chain_valid[NUM_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_ready && chain_valid[NUM_CELLS]) begin
            r_sine   <= n_sine;
            r_cosine <= n_cosine;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_sine_val   = signed'(r_sine);
    assign o_cosine_val = signed'(r_cosine);

endmodule
